// ----- rtl/core/tpdf_pkg.sv -----
// tpdf_pkg: widths, register codes, reset seeds and the xorshift step shared
// by the TPDF dither requantizer and its channel interfaces.
// Depends on nothing.
`default_nettype none

package tpdf_pkg;

  localparam int SAMPLE_IN_W  = 24;
  localparam int SAMPLE_OUT_W = 16;
  localparam int GEN_W        = 32;
  localparam int CFG_IDX_W    = 1;

  typedef logic signed [SAMPLE_IN_W-1:0]  sample_in_t;
  typedef logic signed [SAMPLE_OUT_W-1:0] sample_out_t;
  typedef logic [GEN_W-1:0]               gen_t;
  typedef logic [CFG_IDX_W-1:0]           cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t CFG_SEED_A = 1'b0;
  localparam cfg_idx_t CFG_SEED_B = 1'b1;

  // Seed values after reset
  localparam gen_t SEED_A_RESET = 32'h4761_032D;
  localparam gen_t SEED_B_RESET = 32'h2DCF_E98B;

  // Saturation limits
  localparam sample_out_t OUT_MAX = 16'sh7FFF;
  localparam sample_out_t OUT_MIN = 16'sh8000;

  // One xorshift32 step, shifts 13, 17, 5
  function automatic gen_t xs_next(input gen_t x);
    gen_t t;
    t = x ^ (x << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tpdf_if.sv -----
// tpdf_if: valid/ready channel interfaces for samples in, results out and
// seed register writes. Depends on tpdf_pkg.
`default_nettype none

interface tpdf_in_if import tpdf_pkg::*; ();
  logic       valid;
  logic       ready;
  sample_in_t sample_in;
  logic       last_in;

  modport source (output valid, output sample_in, output last_in, input ready);
  modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

interface tpdf_out_if import tpdf_pkg::*; ();
  logic        valid;
  logic        ready;
  sample_out_t sample_out;
  logic        clipped;
  logic        last_out;

  modport source (output valid, output sample_out, output clipped, output last_out,
                  input ready);
  modport sink   (input valid, input sample_out, input clipped, input last_out,
                  output ready);
endinterface

interface tpdf_cfg_if import tpdf_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  gen_t     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tpdf_dither_24_to_16_core.sv -----
// TPDF dither requantizer, signed 24-bit to signed 16-bit.
//
// Channels: samples (sink) carries sample_in and last_in; results (source)
// carries sample_out, clipped and last_out; cfg (sink) writes seed_a
// (index 0) or seed_b (index 1), which also reloads that generator. cfg is
// always ready; the user must write it only while the block is idle, which
// the block does not enforce. A beat accepted at a clock edge is loaded into
// the result register at that edge. Throughput: one sample per cycle unless
// the result side stalls; the xorshift steps, the dither add, the shift and
// saturation sit between the input handshake and the single result register.
// When the receiver stalls, the result register holds its beat and samples
// still flows as long as that register will be emptied in the same cycle;
// otherwise samples.ready drops until the result is taken.
// A beat with last_in set reloads both generators from their seeds after
// use, so each buffer starts from the same dither sequence.
// Reset (rst, synchronous) empties the result register and restores the
// default seeds and generator states.
// Depends on tpdf_pkg and tpdf_if.
`default_nettype none

module tpdf_dither_24_to_16_core import tpdf_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  tpdf_in_if.sink     samples,
  tpdf_out_if.source  results,
  tpdf_cfg_if.sink    cfg
);

  gen_t seed_a;
  gen_t seed_b;
  gen_t gen_a;
  gen_t gen_b;
  gen_t gen_a_next;
  gen_t gen_b_next;

  logic              out_valid;
  sample_out_t       out_sample;
  logic              out_clipped;
  logic              out_last;

  logic              take;
  logic              cfg_wr;
  logic signed [8:0] dither;
  logic signed [SAMPLE_IN_W:0]   sum;
  logic signed [SAMPLE_OUT_W:0]  shifted;
  sample_out_t       sat_sample;
  logic              sat_clip;

  // Handshakes
  assign samples.ready = !out_valid || results.ready;
  assign take          = samples.valid && samples.ready;
  assign cfg.ready     = 1'b1;
  assign cfg_wr        = cfg.valid;

  // Advance both generators
  assign gen_a_next = xs_next(gen_a);
  assign gen_b_next = xs_next(gen_b);

  // Triangular dither from the two signed low bytes, add, floor shift by 8
  assign dither  = 9'(signed'(gen_a_next[7:0])) + 9'(signed'(gen_b_next[7:0]));
  assign sum     = (SAMPLE_IN_W+1)'(samples.sample_in) + (SAMPLE_IN_W+1)'(dither);
  assign shifted = sum[SAMPLE_IN_W:8];

  // Saturate to 16 bits
  always_comb begin
    sat_clip   = 1'b0;
    sat_sample = shifted[SAMPLE_OUT_W-1:0];
    if (!shifted[SAMPLE_OUT_W] && shifted[SAMPLE_OUT_W-1]) begin
      sat_sample = OUT_MAX;
      sat_clip   = 1'b1;
    end else if (shifted[SAMPLE_OUT_W] && !shifted[SAMPLE_OUT_W-1]) begin
      sat_sample = OUT_MIN;
      sat_clip   = 1'b1;
    end
  end

  // Seeds and generator state: cfg writes reload, accepted beats advance,
  // end of buffer restores the seeds
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_a <= SEED_A_RESET;
      seed_b <= SEED_B_RESET;
      gen_a  <= SEED_A_RESET;
      gen_b  <= SEED_B_RESET;
    end else if (cfg_wr) begin
      unique case (cfg.index)
        CFG_SEED_A: begin
          seed_a <= cfg.data;
          gen_a  <= cfg.data;
        end
        CFG_SEED_B: begin
          seed_b <= cfg.data;
          gen_b  <= cfg.data;
        end
        default: begin
        end
      endcase
    end else if (take) begin
      if (samples.last_in) begin
        gen_a <= seed_a;
        gen_b <= seed_b;
      end else begin
        gen_a <= gen_a_next;
        gen_b <= gen_b_next;
      end
    end
  end

  // Result register valid: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_sample  <= sat_sample;
      out_clipped <= sat_clip;
      out_last    <= samples.last_in;
    end
  end

  assign results.valid      = out_valid;
  assign results.sample_out = out_sample;
  assign results.clipped    = out_clipped;
  assign results.last_out   = out_last;

`ifndef NO_ASSERTIONS
  // End of buffer restores both generators from their seeds
  a_last_reload: assert property (@(posedge clk) disable iff (rst)
    (take && samples.last_in && !cfg_wr) |=> (gen_a == seed_a && gen_b == seed_b))
    else $error("generators not reloaded after last beat");

  // A seed_a write loads generator A too
  a_cfg_load_a: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && cfg.index == CFG_SEED_A) |=> (gen_a == seed_a))
    else $error("seed_a write did not load generator A");

  // A clipped result sits at one of the limits
  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_clipped) |-> (out_sample == OUT_MAX || out_sample == OUT_MIN))
    else $error("clipped result not at a limit");

  // A stalled result blocks new samples
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !results.ready) |-> !samples.ready)
    else $error("sample accepted over a stalled result");

  // Generators move only on an accepted beat or a seed write
  a_gen_hold: assert property (@(posedge clk) disable iff (rst)
    (!take && !cfg_wr) |=> ($stable(gen_a) && $stable(gen_b)))
    else $error("generator changed without a beat");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// tb: self-checking bench for the TPDF dither requantizer core; drives samples
// in bursts, stalls the result side and predicts every result beat.
// Depends on tpdf_pkg, tpdf_if and tpdf_dither_24_to_16_core.
`default_nettype none

module tb;
  import tpdf_pkg::*;

  typedef struct {
    sample_out_t sample_out;
    logic        clipped;
    logic        last_out;
  } dither_result_t;

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_stall_e;

  // Dither predictor and store of expected result beats
  class dither_scoreboard;
    gen_t seed_a, seed_b, gen_a, gen_b;
    dither_result_t expected_q[$];
    int errors;

    function void reset_state();
      seed_a = SEED_A_RESET;
      seed_b = SEED_B_RESET;
      gen_a  = seed_a;
      gen_b  = seed_b;
      errors = 0;
    endfunction

    function gen_t advance(gen_t x);
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      return x;
    endfunction

    // Seed write also reloads its generator
    function void write_seed(cfg_idx_t idx, gen_t val);
      case (idx)
        CFG_SEED_A: begin
          seed_a = val;
          gen_a  = val;
        end
        CFG_SEED_B: begin
          seed_b = val;
          gen_b  = val;
        end
        default: ;
      endcase
    endfunction

    function void note_sample(sample_in_t s, logic last);
      logic signed [7:0] byte_a, byte_b;
      int dither, total, shifted;
      dither_result_t r;
      gen_a  = advance(gen_a);
      gen_b  = advance(gen_b);
      byte_a = gen_a[7:0];
      byte_b = gen_b[7:0];
      dither = int'(byte_a) + int'(byte_b);
      total  = int'(s) + dither;
      // floor shift, then saturate to 16 bits
      shifted   = total >>> 8;
      r.clipped = 1'b0;
      if (shifted > int'(OUT_MAX)) begin
        shifted   = int'(OUT_MAX);
        r.clipped = 1'b1;
      end else if (shifted < int'(OUT_MIN)) begin
        shifted   = int'(OUT_MIN);
        r.clipped = 1'b1;
      end
      r.sample_out = sample_out_t'(shifted);
      r.last_out   = last;
      expected_q.push_back(r);
      // end of buffer restarts both dither sequences
      if (last) begin
        gen_a = seed_a;
        gen_b = seed_b;
      end
    endfunction

    function void check_result(sample_out_t so, logic clip, logic last);
      dither_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: sample_out %0d", $time, so);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (so !== e.sample_out) begin
        $display("%0t: sample_out expected %0d actual %0d", $time, e.sample_out, so);
        errors++;
      end
      if (clip !== e.clipped) begin
        $display("%0t: clipped expected %0b actual %0b", $time, e.clipped, clip);
        errors++;
      end
      if (last !== e.last_out) begin
        $display("%0t: last_out expected %0b actual %0b", $time, e.last_out, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  tpdf_in_if  in_ch ();
  tpdf_out_if out_ch ();
  tpdf_cfg_if cfg_ch ();

  tpdf_dither_24_to_16_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (in_ch),
    .results (out_ch),
    .cfg     (cfg_ch)
  );

  dither_scoreboard sb;
  rx_stall_e        stall_mode = RX_ALWAYS;
  int               max_gap = 0;
  int               rx_cycle = 0;
  int               stall_left = 0;

  always #5 clk = ~clk;

  // Receiver stall pattern, changed on the falling edge
  always @(negedge clk) begin
    rx_cycle++;
    case (stall_mode)
      RX_ALWAYS:   out_ch.ready = 1'b1;
      RX_RANDOM:   out_ch.ready = ($urandom_range(0, 3) != 0);
      RX_PERIODIC: out_ch.ready = ((rx_cycle % 7) < 4);
      RX_LONG: begin
        if (stall_left > 0) begin
          stall_left--;
          out_ch.ready = 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          stall_left   = $urandom_range(1, 20);
          out_ch.ready = 1'b0;
        end else begin
          out_ch.ready = 1'b1;
        end
      end
      default: out_ch.ready = 1'b1;
    endcase
  end

  // Watch all three channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.sample_out, out_ch.clipped, out_ch.last_out);
      if (in_ch.valid && in_ch.ready)
        sb.note_sample(in_ch.sample_in, in_ch.last_in);
      if (cfg_ch.valid && cfg_ch.ready)
        sb.write_seed(cfg_ch.index, cfg_ch.data);
    end
  end

  // Hold one sample beat until it is taken
  task automatic send_sample(input sample_in_t s, input logic last);
    @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.sample_in = s;
    in_ch.last_in   = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop the sample channel and let every expected result drain
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input gen_t val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_seeds(input gen_t a, input gen_t b);
    wait_idle();
    write_reg(CFG_SEED_A, a);
    write_reg(CFG_SEED_B, b);
  endtask

  // Random buffers of random length, sent in bursts
  task automatic run_random_phase(input int n_items);
    int buf_left, burst_left, gap;
    sample_in_t s;
    logic last;
    buf_left   = $urandom_range(1, 40);
    burst_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
        if (gap > 0) begin
          @(negedge clk);
          in_ch.valid     = 1'b0;
          in_ch.sample_in = sample_in_t'($urandom);
          in_ch.last_in   = 1'($urandom);
          repeat (gap - 1) @(negedge clk);
        end
      end
      burst_left--;
      case ($urandom_range(0, 7))
        0:       s = sample_in_t'(24'sh7FFFFF - $urandom_range(0, 511));
        1:       s = sample_in_t'(24'sh800000 + $urandom_range(0, 511));
        2:       s = sample_in_t'($urandom_range(0, 1023) - 512);
        default: s = sample_in_t'($urandom);
      endcase
      buf_left--;
      last = (buf_left == 0) || (i == n_items - 1);
      if (buf_left == 0) buf_left = $urandom_range(1, 40);
      send_sample(s, last);
    end
  endtask

  initial begin
    gen_t a, b;
    sb = new();
    sb.reset_state();
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    in_ch.last_in   = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_SEED_A;
    cfg_ch.data     = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset seeds: rails, zero, rounding edges, buffer ends
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sh000000, 1'b0);
    send_sample(24'shFFFFFF, 1'b0);
    send_sample(24'sh000001, 1'b0);
    send_sample(24'sh7FFF80, 1'b1);
    send_sample(24'sh800080, 1'b0);
    send_sample(24'sh00007F, 1'b0);
    send_sample(24'shFFFF80, 1'b0);
    send_sample(24'sh000080, 1'b1);

    // Both generators off: plain floor shift
    set_seeds(32'h0, 32'h0);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sh0000FF, 1'b0);
    send_sample(24'sh000100, 1'b0);
    send_sample(24'shFFFF00, 1'b0);
    send_sample(24'shFFFEFF, 1'b1);

    // One generator off, back-to-back buffer ends
    set_seeds(32'hFFFF_FFFF, 32'h0);
    send_sample(24'sh400000, 1'b0);
    send_sample(24'shC00000, 1'b0);
    send_sample(24'sh7FFFFF, 1'b1);
    send_sample(24'sh7FFFFF, 1'b1);

    set_seeds(32'h1, 32'hFFFF_FFFF);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sh000000, 1'b1);

    // Random phases over seeds, stall patterns and gaps
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin a = SEED_A_RESET;  b = SEED_B_RESET;  end
        1: begin a = 32'h0;         b = $urandom;      end
        2: begin a = 32'h8000_0000; b = 32'hFFFF_FFFF; end
        default: begin a = $urandom; b = $urandom; end
      endcase
      set_seeds(a, b);
      stall_mode = rx_stall_e'(p % 4);
      max_gap    = (p == 0 || p == 3) ? 0 : 8;
      run_random_phase(115);
    end

    stall_mode = RX_ALWAYS;
    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
